FILE: design/long_press_button_controller_macros.svh
// ----------------------------------------------------------------------------
// Long-press button controller assertion macros
// Short forms for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef LONG_PRESS_BUTTON_CONTROLLER_MACROS_SVH
`define LONG_PRESS_BUTTON_CONTROLLER_MACROS_SVH

// An implication in the same cycle, switched off while reset is high.
`define LPBC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("long press button controller check failed");

// An implication into the next cycle, switched off while reset is high.
`define LPBC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("long press button controller check failed");

// An implication into the next cycle that also holds across reset.
`define LPBC_ASSERT_NXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("long press button controller check failed");

`endif

FILE: design/lpbc_pkg.sv
// ----------------------------------------------------------------------------
// Long-press button controller package
// Widths, register indexes, result codes and shared structures.
// ----------------------------------------------------------------------------
package lpbc_pkg;

   localparam int GPIO_W       = 24;
   localparam int TICKS_W      = 6;
   localparam int RST_CNT_W    = 8;
   localparam int SET_CNT_W    = 5;
   localparam int CSR_IDX_W    = 3;
   localparam int RSP_DATA_W   = 8;

   // Setup button timing, in ticks.
   localparam logic [SET_CNT_W-1:0] SETUP_WAIT  = SET_CNT_W'(3);
   localparam logic [SET_CNT_W-1:0] SETUP_PHASE = SET_CNT_W'(5);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RESET_MASK   = 3'd0,
      CSR_RESET_LEVEL  = 3'd1,
      CSR_SETUP_MASK   = 3'd2,
      CSR_SETUP_LEVEL  = 3'd3,
      CSR_RESET_WAIT   = 3'd4,
      CSR_RESET_PHASE  = 3'd5,
      CSR_POWER_OFF_EN = 3'd6,
      CSR_LED_ON_LEVEL = 3'd7
   } csr_index_type;

   // Tick rate requests.
   typedef enum logic [1:0] {
      RATE_NONE   = 2'd0,
      RATE_FAST   = 2'd1,
      RATE_NORMAL = 2'd2,
      RATE_STOP   = 2'd3
   } rate_type;

   // Reset button actions.
   typedef enum logic [1:0] {
      ACTION_NONE      = 2'd0,
      ACTION_POWER_OFF = 2'd1,
      ACTION_FACTORY   = 2'd2
   } action_type;

   // Configuration as held by the register file.
   typedef struct packed {
      logic [GPIO_W-1:0]  rst_btn_mask;
      logic [GPIO_W-1:0]  reset_level;
      logic [GPIO_W-1:0]  set_btn_mask;
      logic [GPIO_W-1:0]  setup_level;
      logic [TICKS_W-1:0] rst_wait_ticks;
      logic [TICKS_W-1:0] reset_phase;
      logic               power_off_en;
      logic               led_on_level;
   } cfg_type;

   // What one button decides for the current tick.
   typedef struct packed {
      logic       led_write;
      logic       led_lit;
      rate_type   rate;
      action_type action;
      logic       setup_go;
   } btn_type;

endpackage

FILE: design/long_press_button_controller.sv
// ----------------------------------------------------------------------------
// Long-press button controller
// Watches a reset and a setup button in sampled GPIO words and drives the
// ready LED, tick rate requests and release actions.
// ----------------------------------------------------------------------------
// One GPIO word enters per clock cycle while no stage is stalled; it passes
// through the input register and then the result register. Both stages move
// whenever the result register is empty or being taken, so a steady flow
// sustains one word per cycle; rsp_tready stalls both stages. The
// hold counters advance as each word passes from the input register to the
// result register, so results come out in order, one for every word.
// Configuration is written through csr_we, csr_index and csr_wdata; the user
// must write it only while no word is in flight, which the block does not enforce.
module long_press_button_controller (
   input  logic                           clock,
   input  logic                           reset,
   // Input words.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [lpbc_pkg::GPIO_W-1:0]    req_tdata,   // [23:0] gpio_sample
   // Result words.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] led_write, [1] led_pin_level, [3:2] tick_rate_request,
   // [5:4] reset_action, [6] setup_action, [7] zero
   output logic [lpbc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Configuration writes.
   input  logic                           csr_we,
   input  logic [lpbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lpbc_pkg::GPIO_W-1:0]    csr_wdata
);
   import lpbc_pkg::*;

   cfg_type                cfg;
   btn_type                reset_res;
   btn_type                setup_res;
   logic                   in_valid_ff;
   logic [GPIO_W-1:0]      in_data_ff;
   logic                   out_valid_ff;
   logic [RSP_DATA_W-1:0]  out_data_ff;
   logic [RSP_DATA_W-1:0]  out_data_in;
   logic                   advance;
   logic                   step;
   logic                   led_write;
   logic                   led_lit;
   logic                   led_level;

   lpbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lpbc_reset_btn u_reset_btn (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .gpio_sample (in_data_ff),
      .cfg         (cfg),
      .result      (reset_res)
   );

   lpbc_setup_btn u_setup_btn (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .gpio_sample (in_data_ff),
      .cfg         (cfg),
      .result      (setup_res)
   );

   // Both stages move together when the result register can take a word.
   assign advance    = ~out_valid_ff | rsp_tready;
   assign step       = advance & in_valid_ff;
   assign req_tready = ~in_valid_ff | advance;

   // The setup button is handled last, so its LED level wins.
   assign led_write = reset_res.led_write | setup_res.led_write;
   assign led_lit   = setup_res.led_write ? setup_res.led_lit : reset_res.led_lit;
   assign led_level = led_write & (led_lit ? cfg.led_on_level : ~cfg.led_on_level);

   // Pack the result word.
   assign out_data_in = {1'b0, setup_res.setup_go, reset_res.action,
                         reset_res.rate, led_level, led_write};

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_tdata;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: design/lpbc_csr.sv
// ----------------------------------------------------------------------------
// Long-press button controller register file
// Holds the configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module lpbc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [lpbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lpbc_pkg::GPIO_W-1:0]    csr_wdata,
   output lpbc_pkg::cfg_type              cfg
);
   import lpbc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RESET_MASK:   cfg_in.rst_btn_mask   = csr_wdata;
            CSR_RESET_LEVEL:  cfg_in.reset_level    = csr_wdata;
            CSR_SETUP_MASK:   cfg_in.set_btn_mask   = csr_wdata;
            CSR_SETUP_LEVEL:  cfg_in.setup_level    = csr_wdata;
            CSR_RESET_WAIT:   cfg_in.rst_wait_ticks = csr_wdata[TICKS_W-1:0];
            CSR_RESET_PHASE:  cfg_in.reset_phase    = csr_wdata[TICKS_W-1:0];
            CSR_POWER_OFF_EN: cfg_in.power_off_en   = csr_wdata[0];
            CSR_LED_ON_LEVEL: cfg_in.led_on_level   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // The registers, with their documented reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rst_btn_mask   <= '0;
         cfg_ff.reset_level    <= '0;
         cfg_ff.set_btn_mask   <= '0;
         cfg_ff.setup_level    <= '0;
         cfg_ff.rst_wait_ticks <= TICKS_W'(30);
         cfg_ff.reset_phase    <= TICKS_W'(50);
         cfg_ff.power_off_en   <= 1'b0;
         cfg_ff.led_on_level   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/lpbc_reset_btn.sv
// ----------------------------------------------------------------------------
// Long-press button controller, reset button
// Hold counter and phase decisions for the reset button.
// ----------------------------------------------------------------------------
module lpbc_reset_btn (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [lpbc_pkg::GPIO_W-1:0] gpio_sample,
   input  lpbc_pkg::cfg_type           cfg,
   output lpbc_pkg::btn_type           result
);
   import lpbc_pkg::*;

   localparam logic [RST_CNT_W-1:0] CNT_MAX = {RST_CNT_W{1'b1}};

   logic [RST_CNT_W-1:0] count_ff;
   logic [RST_CNT_W-1:0] count_in;
   logic [RST_CNT_W-1:0] count_inc;
   logic [RST_CNT_W-1:0] wait_ext;
   logic [RST_CNT_W-1:0] phase_ext;
   logic [RST_CNT_W-1:0] two_phase;
   logic [RST_CNT_W-1:0] k_press;
   logic [RST_CNT_W-1:0] k_rel;
   logic                 pressed;

   assign pressed   = (gpio_sample & cfg.rst_btn_mask) == cfg.reset_level;
   assign count_inc = (count_ff < CNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign wait_ext  = RST_CNT_W'(cfg.rst_wait_ticks);
   assign phase_ext = RST_CNT_W'(cfg.reset_phase);
   assign two_phase = RST_CNT_W'({cfg.reset_phase, 1'b0});
   assign k_press   = count_inc - wait_ext;
   assign k_rel     = count_ff - wait_ext;

   // Phase decisions for one tick.
   always_comb begin
      result   = '0;
      count_in = count_ff;
      if (cfg.rst_btn_mask != '0) begin
         if (pressed) begin
            count_in = count_inc;
            if (count_inc < wait_ext) begin
               if (count_inc == RST_CNT_W'(1)) begin
                  result.rate = RATE_FAST;
               end
            end else if ((k_press < phase_ext) && cfg.power_off_en) begin
               // Steady off while power-off is armed.
               result.led_write = 1'b1;
               result.led_lit   = 1'b0;
            end else if (k_press < two_phase) begin
               result.led_write = 1'b1;
               result.led_lit   = ~count_inc[0];
            end else begin
               // Past the last phase the count starts over.
               count_in         = '0;
               result.led_write = 1'b1;
               result.led_lit   = 1'b1;
            end
         end else begin
            count_in = '0;
            if (count_ff < wait_ext) begin
               if (count_ff != '0) begin
                  result.rate      = RATE_NORMAL;
                  result.led_write = 1'b1;
                  result.led_lit   = 1'b1;
               end
            end else if ((k_rel < phase_ext) && cfg.power_off_en) begin
               result.rate   = RATE_STOP;
               result.action = ACTION_POWER_OFF;
            end else if (k_rel < two_phase) begin
               result.rate   = RATE_STOP;
               result.action = ACTION_FACTORY;
            end
         end
      end
   end

   // The counter moves only when a tick is passed on.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/lpbc_setup_btn.sv
// ----------------------------------------------------------------------------
// Long-press button controller, setup button
// Hold counter and the single blinking phase of the setup button.
// ----------------------------------------------------------------------------
module lpbc_setup_btn (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [lpbc_pkg::GPIO_W-1:0] gpio_sample,
   input  lpbc_pkg::cfg_type           cfg,
   output lpbc_pkg::btn_type           result
);
   import lpbc_pkg::*;

   localparam logic [SET_CNT_W-1:0] CNT_MAX = {SET_CNT_W{1'b1}};

   logic [SET_CNT_W-1:0] count_ff;
   logic [SET_CNT_W-1:0] count_in;
   logic [SET_CNT_W-1:0] count_inc;
   logic [SET_CNT_W-1:0] k_press;
   logic [SET_CNT_W-1:0] k_rel;
   logic                 pressed;

   assign pressed   = (gpio_sample & cfg.set_btn_mask) == cfg.setup_level;
   assign count_inc = (count_ff < CNT_MAX) ? count_ff + 1'b1 : count_ff;
   assign k_press   = count_inc - SETUP_WAIT;
   assign k_rel     = count_ff - SETUP_WAIT;

   // Phase decisions for one tick.
   always_comb begin
      result   = '0;
      count_in = count_ff;
      if (cfg.set_btn_mask != '0) begin
         if (pressed) begin
            count_in = count_inc;
            if (count_inc >= SETUP_WAIT) begin
               result.led_write = 1'b1;
               if (k_press < SETUP_PHASE) begin
                  result.led_lit = ~count_inc[0];
               end else begin
                  count_in       = '0;
                  result.led_lit = 1'b1;
               end
            end
         end else begin
            count_in = '0;
            if (count_ff < SETUP_WAIT) begin
               if (count_ff != '0) begin
                  result.led_write = 1'b1;
                  result.led_lit   = 1'b1;
               end
            end else if (k_rel < SETUP_PHASE) begin
               result.led_write = 1'b1;
               result.led_lit   = 1'b1;
               result.setup_go  = 1'b1;
            end
         end
      end
   end

   // The counter moves only when a tick is passed on.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: design/lpbc_checker.sv
// ----------------------------------------------------------------------------
// Long-press button controller port checker
// Concurrent checks on the top level's ports, attached by a bind.
// ----------------------------------------------------------------------------
`include "long_press_button_controller_macros.svh"

module lpbc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [lpbc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import lpbc_pkg::*;

   logic [1:0] rsp_rate;
   logic [1:0] rsp_action;

   assign rsp_rate   = rsp_tdata[3:2];
   assign rsp_action = rsp_tdata[5:4];

   // A stalled result word holds its value.
   `LPBC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))

   // The LED level is only raised on a tick that drives the pin.
   `LPBC_ASSERT_IMP(a_led_level, clock, reset, rsp_tvalid && rsp_tdata[1], rsp_tdata[0])

   // Every release action comes with a stop request, and no unknown action.
   `LPBC_ASSERT_IMP(a_action_stop, clock, reset, rsp_tvalid && (rsp_action != ACTION_NONE), (rsp_rate == RATE_STOP) && (rsp_action != 2'd3))

   // With the result register empty the input side is always open.
   `LPBC_ASSERT_IMP(a_ready_empty, clock, reset, !rsp_tvalid, req_tready)

   // Reset leaves no result word behind.
   `LPBC_ASSERT_NXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind long_press_button_controller lpbc_checker u_lpbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/long_press_button_controller_test.sv
// ----------------------------------------------------------------------------
// Long-press button controller testbench
// Streams GPIO words into the controller and compares every result word with
// a cycle-free model of the two hold counters. A short directed part is
// followed by random press, hold and release sequences under several
// register settings and three patterns of idling on the two streams.
// ----------------------------------------------------------------------------
module long_press_button_controller_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lpbc_pkg::*;

   // One expected result word, field by field.
   typedef struct packed {
      logic       led_write;
      logic       led_level;
      rate_type   rate;
      action_type action;
      logic       setup_go;
   } tick_result_type;

   localparam int STALL_LIMIT = 2000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [GPIO_W-1:0]     req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [GPIO_W-1:0]     csr_wdata  = '0;

   // Model state: the register copy and both hold counters.
   cfg_type                button_cfg;
   logic [RST_CNT_W-1:0]   reset_hold = '0;
   logic [SET_CNT_W-1:0]   setup_hold = '0;

   tick_result_type expected_ticks[$];
   int              error_count      = 0;
   int              words_sent       = 0;
   int              words_checked    = 0;
   int              settings_written = 0;
   int              send_idle_pct    = 0;
   int              recv_idle_pct    = 0;
   int              stall_cycles     = 0;

   long_press_button_controller i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [23:0] gpio_sample
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // [0] led_write, [1] led_pin_level, [3:2] tick_rate_request,
      // [5:4] reset_action, [6] setup_action, [7] zero
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Clock with an 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // The ready LED is driven lit or dark; the pin level follows the polarity.
   function automatic void light_led(inout tick_result_type r, input bit lit);
      r.led_write = 1'b1;
      r.led_level = lit ? button_cfg.led_on_level : !button_cfg.led_on_level;
   endfunction

   // Works out the result word of one tick and advances both hold counters.
   function automatic tick_result_type predict_tick(input logic [GPIO_W-1:0] sample);
      tick_result_type r;
      int unsigned     wait_t;
      int unsigned     phase_t;
      int unsigned     k;
      r       = '0;
      wait_t  = button_cfg.rst_wait_ticks;
      phase_t = button_cfg.reset_phase;

      // The reset button is handled first.
      if (button_cfg.rst_btn_mask != '0) begin
         if ((sample & button_cfg.rst_btn_mask) == button_cfg.reset_level) begin
            if (reset_hold != '1)
               reset_hold = reset_hold + 1'b1;
            if (reset_hold < wait_t) begin
               if (reset_hold == 1)
                  r.rate = RATE_FAST;
            end else begin
               k = reset_hold - wait_t;
               if (k < phase_t && button_cfg.power_off_en)
                  light_led(r, 1'b0);
               else if (k < 2 * phase_t)
                  light_led(r, !reset_hold[0]);
               else begin
                  reset_hold = '0;
                  light_led(r, 1'b1);
               end
            end
         end else begin
            if (reset_hold < wait_t) begin
               if (reset_hold != 0) begin
                  r.rate = RATE_NORMAL;
                  light_led(r, 1'b1);
               end
            end else begin
               k = reset_hold - wait_t;
               if (k < phase_t && button_cfg.power_off_en) begin
                  r.rate   = RATE_STOP;
                  r.action = ACTION_POWER_OFF;
               end else if (k < 2 * phase_t) begin
                  r.rate   = RATE_STOP;
                  r.action = ACTION_FACTORY;
               end
            end
            reset_hold = '0;
         end
      end

      // The setup button comes last, so its LED level wins.
      if (button_cfg.set_btn_mask != '0) begin
         if ((sample & button_cfg.set_btn_mask) == button_cfg.setup_level) begin
            if (setup_hold != '1)
               setup_hold = setup_hold + 1'b1;
            if (setup_hold >= SETUP_WAIT) begin
               if (setup_hold - SETUP_WAIT < SETUP_PHASE)
                  light_led(r, !setup_hold[0]);
               else begin
                  setup_hold = '0;
                  light_led(r, 1'b1);
               end
            end
         end else begin
            if (setup_hold < SETUP_WAIT) begin
               if (setup_hold != 0)
                  light_led(r, 1'b1);
            end else if (setup_hold - SETUP_WAIT < SETUP_PHASE) begin
               light_led(r, 1'b1);
               r.setup_go = 1'b1;
            end
            setup_hold = '0;
         end
      end
      return r;
   endfunction

   // Sends one GPIO word, with a random gap first, and records its result.
   task automatic send_sample(input logic [GPIO_W-1:0] sample);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= sample;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_ticks.push_back(predict_tick(sample));
      words_sent++;
   endtask

   // Holds the sender back until every result word has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_ticks.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [GPIO_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes all eight registers; narrow ones get random upper bits that the
   // block has to drop.
   task automatic write_config(input cfg_type c);
      write_register(CSR_RESET_MASK,   c.rst_btn_mask);
      write_register(CSR_RESET_LEVEL,  c.reset_level);
      write_register(CSR_SETUP_MASK,   c.set_btn_mask);
      write_register(CSR_SETUP_LEVEL,  c.setup_level);
      write_register(CSR_RESET_WAIT,
                     (GPIO_W'($urandom) & ~GPIO_W'(6'h3F)) | GPIO_W'(c.rst_wait_ticks));
      write_register(CSR_RESET_PHASE,
                     (GPIO_W'($urandom) & ~GPIO_W'(6'h3F)) | GPIO_W'(c.reset_phase));
      write_register(CSR_POWER_OFF_EN,
                     (GPIO_W'($urandom) & ~GPIO_W'(1)) | GPIO_W'(c.power_off_en));
      write_register(CSR_LED_ON_LEVEL,
                     (GPIO_W'($urandom) & ~GPIO_W'(1)) | GPIO_W'(c.led_on_level));
      csr_we     <= 1'b0;
      button_cfg  = c;
      settings_written++;
   endtask

   task automatic run_sequence(input cfg_type c, input logic [GPIO_W-1:0] seq[$]);
      wait_drained();
      write_config(c);
      foreach (seq[i])
         send_sample(seq[i]);
   endtask

   // Forces a button's bits to pressed, or breaks the pattern if released.
   function automatic logic [GPIO_W-1:0] shape_button(input logic [GPIO_W-1:0] s,
                                                      input logic [GPIO_W-1:0] mask,
                                                      input logic [GPIO_W-1:0] level,
                                                      input bit down);
      if (mask == '0)
         return s;
      if (down)
         return (s & ~mask) | (level & mask);
      if ((s & mask) == level)
         s = s ^ (mask & (~mask + 1'b1));
      return s;
   endfunction

   function automatic logic [TICKS_W-1:0] random_ticks();
      case ($urandom_range(9))
         0:       return 6'd63;
         1:       return 6'd1;
         2:       return 6'd0;
         default: return TICKS_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic logic [GPIO_W-1:0] random_mask(input logic [GPIO_W-1:0] avoid);
      logic [GPIO_W-1:0] m;
      m = GPIO_W'($urandom & $urandom) & ~avoid;
      m[$urandom_range(GPIO_W - 1)] = 1'b1;
      return m;
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      c.rst_btn_mask   = ($urandom_range(9) == 0) ? '0 : random_mask('0);
      c.reset_level    = ($urandom_range(7) == 0) ? GPIO_W'($urandom)
                                                  : c.rst_btn_mask & GPIO_W'($urandom);
      c.set_btn_mask   = ($urandom_range(9) == 0) ? '0 : random_mask(c.rst_btn_mask);
      c.setup_level    = ($urandom_range(7) == 0) ? GPIO_W'($urandom)
                                                  : c.set_btn_mask & GPIO_W'($urandom);
      c.rst_wait_ticks = random_ticks();
      c.reset_phase    = random_ticks();
      c.power_off_en   = 1'($urandom_range(1));
      c.led_on_level   = 1'($urandom_range(1));
      return c;
   endfunction

   // Directed words: every release outcome, the reset button's wrap, both
   // buttons at once, a disabled button, a level outside its mask and zero timing.
   task automatic test_directed();
      cfg_type c;
      send_idle_pct = 18;
      recv_idle_pct = 88;

      // Fast timing with the power-off phase enabled.
      c = '{rst_btn_mask: 24'h000001, reset_level: 24'h000001,
            set_btn_mask: 24'h000002, setup_level: 24'h000002,
            rst_wait_ticks: 6'd1, reset_phase: 6'd1, power_off_en: 1'b1,
            led_on_level: 1'b1};
      run_sequence(c, '{24'h000000, 24'h000001, 24'h000000,
                        24'h000001, 24'h000001, 24'h000000,
                        24'h000001, 24'h000001, 24'h000001,
                        24'hFFFFFF, 24'hFFFFFE,
                        24'h000002, 24'h000002, 24'h000002, 24'h000000,
                        24'h000002, 24'h000000});

      // Longest timing, full-width reset button, setup button disabled.
      c = '{rst_btn_mask: 24'hFFFFFF, reset_level: 24'hFFFFFF,
            set_btn_mask: 24'h000000, setup_level: 24'h000000,
            rst_wait_ticks: 6'd63, reset_phase: 6'd63, power_off_en: 1'b0,
            led_on_level: 1'b0};
      run_sequence(c, '{24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF});

      // Zero wait and phase; the setup level lies outside its mask.
      c = '{rst_btn_mask: 24'h000100, reset_level: 24'h000100,
            set_btn_mask: 24'h00000F, setup_level: 24'h0000F0,
            rst_wait_ticks: 6'd0, reset_phase: 6'd0, power_off_en: 1'b1,
            led_on_level: 1'b0};
      run_sequence(c, '{24'h000100, 24'h000000, 24'hFFFFFF});
   endtask

   // Random press and hold runs, with a tenth of the words pure noise.
   task automatic test_random(input int send_pct, input int recv_pct);
      cfg_type           c;
      bit                reset_down;
      bit                setup_down;
      int                reset_left;
      int                setup_left;
      int                words;
      logic [GPIO_W-1:0] s;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int seg = 0; seg < 6; seg++) begin
         if (seg == 0)
            c = '{rst_btn_mask: 24'hFFFFFF, reset_level: 24'hFFFFFF,
                  set_btn_mask: 24'hFFFFFF, setup_level: 24'h000000,
                  rst_wait_ticks: 6'd63, reset_phase: 6'd63,
                  power_off_en: 1'($urandom), led_on_level: 1'($urandom)};
         else if (seg == 1)
            c = '{rst_btn_mask: 24'h800000, reset_level: 24'h000000,
                  set_btn_mask: 24'h000001, setup_level: 24'h000001,
                  rst_wait_ticks: 6'd1, reset_phase: 6'd1,
                  power_off_en: 1'($urandom), led_on_level: 1'($urandom)};
         else
            c = random_config();
         wait_drained();
         write_config(c);
         reset_down = 1'b0;
         setup_down = 1'b0;
         reset_left = 0;
         setup_left = 0;
         words      = (seg == 0) ? 150 : 60;
         for (int n = 0; n < words; n++) begin
            if (reset_left == 0) begin
               reset_down = !reset_down;
               reset_left = reset_down
                          ? $urandom_range(1, c.rst_wait_ticks + 2 * c.reset_phase + 2)
                          : $urandom_range(1, 4);
            end
            if (setup_left == 0) begin
               setup_down = !setup_down;
               setup_left = setup_down ? $urandom_range(1, SETUP_WAIT + SETUP_PHASE + 2)
                                       : $urandom_range(1, 4);
            end
            reset_left--;
            setup_left--;
            s = GPIO_W'($urandom);
            if ($urandom_range(9) != 0) begin
               s = shape_button(s, c.rst_btn_mask, c.reset_level, reset_down);
               s = shape_button(s, c.set_btn_mask, c.setup_level, setup_down);
            end
            // The sender also pauses once mid-run until the block is empty.
            if (seg == 2 && n == 30)
               wait_drained();
            send_sample(s);
         end
      end
   endtask

   // The receiver is ready at random.
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   function automatic void check_field(input string name, input logic [1:0] want,
                                       input logic [1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Each result word taken is compared with the oldest expectation.
   always @(posedge clock) begin
      tick_result_type exp_word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_ticks.size() == 0) begin
            $error("result word 0x%0h arrived with no expectation waiting", rsp_tdata);
            error_count++;
         end else begin
            exp_word = expected_ticks.pop_front();
            check_field("led_write",         exp_word.led_write, rsp_tdata[0]);
            check_field("led_pin_level",     exp_word.led_level, rsp_tdata[1]);
            check_field("tick_rate_request", exp_word.rate,      rsp_tdata[3:2]);
            check_field("reset_action",      exp_word.action,    rsp_tdata[5:4]);
            check_field("setup_action",      exp_word.setup_go,  rsp_tdata[6]);
            words_checked++;
         end
      end
   end

   // Watchdog: too long without a word taken on either stream ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog expired after %0d idle cycles.", stall_cycles);
         $display("[long_press_button_controller] ERROR");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   initial begin
      button_cfg = '{rst_btn_mask: '0, reset_level: '0, set_btn_mask: '0, setup_level: '0,
                     rst_wait_ticks: 6'd30, reset_phase: 6'd50,
                     power_off_en: 1'b0, led_on_level: 1'b0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(18, 88);
      test_random(88, 18);
      test_random(0, 0);

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d GPIO words and checked %0d result words under %0d settings,",
               words_sent, words_checked, settings_written);
      $display("covering holds, releases, wraps, disabled buttons and zero timing.");
      if (error_count == 0)
         $display("[long_press_button_controller] OK");
      else
         $display("[long_press_button_controller] ERROR");
      $finish;
   end

endmodule
